// ===== hdl/sar_adc_register_interface_unit_defines.svh =====
// Assertion macros for the SAR ADC register front end.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SAR_ADC_REGISTER_INTERFACE_UNIT_DEFINES_SVH
`define SAR_ADC_REGISTER_INTERFACE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SARIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define SARIF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/sarif_pkg.sv =====
// Shared types, constants and the full-scale table of the SAR ADC register front end.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sarif_pkg;

  localparam int REG_WORDS_DEF     = 64;
  localparam int PADS_PER_UNIT_DEF = 10;

  localparam int WORD_W = 32;
  localparam int WIDX_W = 6;
  localparam int RAW_W  = 12;
  localparam int MV_W   = 12;
  localparam int FS_W   = 12;
  localparam int PROD_W = MV_W + RAW_W;
  localparam int CH_W   = 4;
  localparam int BITS_W = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PAD   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    VAR_CLASSIC = 2'd0,
    VAR_SECOND  = 2'd1,
    VAR_ONESHOT = 2'd2
  } variant_e;

  // word indexes (byte offset / 4)
  localparam logic [WIDX_W-1:0] W_V0_START1 = WIDX_W'(8'h54 >> 2);
  localparam logic [WIDX_W-1:0] W_V0_START2 = WIDX_W'(8'h94 >> 2);
  localparam logic [WIDX_W-1:0] W_V0_ATTEN1 = WIDX_W'(8'h34 >> 2);
  localparam logic [WIDX_W-1:0] W_V1_START1 = WIDX_W'(8'h0C >> 2);
  localparam logic [WIDX_W-1:0] W_V1_START2 = WIDX_W'(8'h30 >> 2);
  localparam logic [WIDX_W-1:0] W_V1_ATTEN1 = WIDX_W'(8'h14 >> 2);
  localparam logic [WIDX_W-1:0] W_ATTEN2    = WIDX_W'(8'h38 >> 2);
  localparam logic [WIDX_W-1:0] W_WIDTH     = WIDX_W'(8'h2C >> 2);
  localparam logic [WIDX_W-1:0] W_OS        = WIDX_W'(8'h20 >> 2);
  localparam logic [WIDX_W-1:0] W_DATA1     = WIDX_W'(8'h2C >> 2);
  localparam logic [WIDX_W-1:0] W_DATA2     = WIDX_W'(8'h30 >> 2);
  localparam logic [WIDX_W-1:0] W_RAWINT    = WIDX_W'(8'h44 >> 2);
  localparam logic [WIDX_W-1:0] W_CLEAR     = WIDX_W'(8'h4C >> 2);

  localparam logic [WORD_W-1:0] WIDTH_RESET   = 32'h0000_000F;
  localparam logic [WORD_W-1:0] DATA_MASK     = 32'h0000_FFFF;
  localparam logic [WORD_W-1:0] DONE_MASK     = 32'h0001_0000;
  localparam logic [WORD_W-1:0] RI_DONE0_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] RI_DONE1_MASK = 32'h4000_0000;

  localparam int START_POS    = 17;
  localparam int EN_LSB       = 19;
  localparam int OS_START_POS = 29;
  localparam int OS_UNIT_POS  = 30;
  localparam int OS_CH_LSB    = 25;
  localparam int OS_AT_LSB    = 23;

  localparam int NCH_MAX = 10;
  localparam logic [CH_W-1:0] NCH_V0_U0 = CH_W'(8);
  localparam logic [CH_W-1:0] NCH_FULL  = CH_W'(NCH_MAX);
  localparam logic [CH_W-1:0] OS_NCH_U0 = CH_W'(5);
  localparam logic [CH_W-1:0] OS_NCH_U1 = CH_W'(1);

  localparam logic [BITS_W-1:0] BITS_MIN  = BITS_W'(9);
  localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(12);

  function automatic logic [FS_W-1:0] full_scale(variant_e v, logic [1:0] at);
    logic [FS_W-1:0] fs;
    fs = '0;
    unique case (v)
      VAR_SECOND: begin
        unique case (at)
          2'd0: fs = FS_W'(850);
          2'd1: fs = FS_W'(1100);
          2'd2: fs = FS_W'(1600);
          default: fs = FS_W'(2900);
        endcase
      end
      VAR_ONESHOT: begin
        unique case (at)
          2'd0: fs = FS_W'(750);
          2'd1: fs = FS_W'(1050);
          2'd2: fs = FS_W'(1300);
          default: fs = FS_W'(2500);
        endcase
      end
      default: begin
        unique case (at)
          2'd0: fs = FS_W'(950);
          2'd1: fs = FS_W'(1250);
          2'd2: fs = FS_W'(1750);
          default: fs = FS_W'(2450);
        endcase
      end
    endcase
    return fs;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sar_adc_register_interface_unit.sv =====
// Register front end of a two-unit SAR ADC: bus reads, bus writes and pad updates.
// Register file reads go through a wait state for the registered read port; on the
// one-shot variant a clear of the interrupt bits is a read-modify-write. A conversion
// uses the shared divider that produces one bit of the 12-bit quotient per cycle;
// a saturated conversion skips it. The register file has one write and one read
// port, so a conversion reads each further word it touches in a state of its own.
// A finished item waits in the output register while the next one is accepted.
// Uses sarif_pkg, sarif_regfile, sarif_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sar_adc_register_interface_unit_defines.svh"

module sar_adc_register_interface_unit
  import sarif_pkg::*;
#(
  parameter int REG_WORDS     = REG_WORDS_DEF,
  parameter int PADS_PER_UNIT = PADS_PER_UNIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              chip_variant_we_i,
  input  logic [1:0]        chip_variant_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        reg_offset_i,
  input  logic [WORD_W-1:0] write_data_i,
  input  logic              pad_unit_i,
  input  logic [CH_W-1:0]   pad_channel_i,
  input  logic [MV_W-1:0]   pad_millivolts_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] read_data_o,
  output logic              conversion_done_o,
  output logic              conversion_unit_o,
  output logic [RAW_W-1:0]  conversion_raw_o
);

  localparam int AW    = $clog2(REG_WORDS);
  localparam int PAD_N = 2 * PADS_PER_UNIT;
  localparam int PIW   = $clog2(PAD_N);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ATTEN,
    S_WIDTH,
    S_CALC,
    S_DIV,
    S_WB,
    S_RMW,
    S_RDWAIT,
    S_OUT
  } state_e;

  state_e             state_q;
  variant_e           variant_q;
  logic [WIDX_W-1:0]  w_q;
  logic [WORD_W-1:0]  data_q;
  logic               unit_q;
  logic               en_q;
  logic [CH_W-1:0]    ch_q;
  logic [1:0]         at_q;
  logic [BITS_W-1:0]  bits_q;
  logic [RAW_W-1:0]   raw_q;
  logic [WORD_W-1:0]  res_rd_q;
  logic               res_done_q;
  logic               res_unit_q;
  logic [RAW_W-1:0]   res_raw_q;
  logic               out_valid_q;
  logic [WORD_W-1:0]  out_rd_q;
  logic               out_done_q;
  logic               out_unit_q;
  logic [RAW_W-1:0]   out_raw_q;
  logic [MV_W-1:0]    pad_q [PAD_N];

  logic               accept;
  logic [WIDX_W-1:0]  in_w;
  logic               in_hit;
  logic               pad_wr;
  logic [PIW-1:0]     pad_widx;
  logic [PIW-1:0]     pad_ridx;

  logic [WIDX_W-1:0]  s1;
  logic [WIDX_W-1:0]  s2;
  logic [WIDX_W-1:0]  a1;
  logic               st01;
  logic               unit01;
  logic [CH_W-1:0]    nch;
  logic               sel_found;
  logic [CH_W-1:0]    sel_ch;
  logic               os_start;
  logic               os_unit;
  logic [CH_W-1:0]    os_ch;
  logic               os_en;

  logic [MV_W-1:0]    mv;
  logic [FS_W-1:0]    fs;
  logic               sat;
  logic [RAW_W:0]     maxraw_full;
  logic [RAW_W-1:0]   maxraw;
  logic [PROD_W-1:0]  dividend;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [RAW_W-1:0]   div_quo;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;
  logic [WORD_W-1:0]  ri_bit;
  logic               out_load;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_w       = reg_offset_i[7:2];
  assign in_hit     = (WORD_W'(in_w) < WORD_W'(REG_WORDS));
  assign pad_wr     = accept && (opcode_i == OP_PAD) &&
                      (WORD_W'(pad_channel_i) < WORD_W'(PADS_PER_UNIT));
  assign pad_widx   = PIW'(pad_unit_i ? PADS_PER_UNIT : 0) + PIW'(pad_channel_i);
  assign pad_ridx   = PIW'(unit_q ? PADS_PER_UNIT : 0) + PIW'(ch_q);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    unique case (variant_q)
      VAR_SECOND: begin
        s1 = W_V1_START1;
        s2 = W_V1_START2;
        a1 = W_V1_ATTEN1;
      end
      default: begin
        s1 = W_V0_START1;
        s2 = W_V0_START2;
        a1 = W_V0_ATTEN1;
      end
    endcase
    st01   = ((w_q == s1) || (w_q == s2)) && data_q[START_POS];
    unit01 = (w_q == s2);
    nch    = ((variant_q == VAR_CLASSIC) && !unit01) ? NCH_V0_U0 : NCH_FULL;

    // lowest enabled pad wins
    sel_found = 1'b0;
    sel_ch    = '0;
    for (int i = NCH_MAX - 1; i >= 0; i--) begin
      if ((CH_W'(i) < nch) && data_q[EN_LSB + i]) begin
        sel_found = 1'b1;
        sel_ch    = CH_W'(i);
      end
    end

    os_start = (w_q == W_OS) && data_q[OS_START_POS];
    os_unit  = data_q[OS_UNIT_POS];
    os_ch    = data_q[OS_CH_LSB +: CH_W];
    os_en    = os_ch < (os_unit ? OS_NCH_U1 : OS_NCH_U0);
  end

  always_comb begin
    mv          = en_q ? pad_q[pad_ridx] : '0;
    fs          = full_scale(variant_q, at_q);
    sat         = (mv >= fs);
    maxraw_full = ((RAW_W + 1)'(1) << bits_q) - (RAW_W + 1)'(1);
    maxraw      = maxraw_full[RAW_W-1:0];
    dividend    = (PROD_W'(mv) << bits_q) - PROD_W'(mv);
    div_start   = (state_q == S_CALC) && !sat;
    ri_bit      = res_unit_q ? RI_DONE1_MASK : RI_DONE0_MASK;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(w_q);
    mem_wdata = data_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(w_q);
    unique case (state_q)
      S_IDLE: begin
        mem_re    = accept && (opcode_i == OP_READ) && in_hit;
        mem_raddr = AW'(in_w);
      end
      S_DECODE: begin
        mem_we = 1'b1;
        if (variant_q == VAR_ONESHOT) begin
          mem_re    = (w_q == W_CLEAR);
          mem_raddr = AW'(W_RAWINT);
        end else begin
          mem_re    = st01;
          mem_raddr = unit01 ? AW'(W_ATTEN2) : AW'(a1);
        end
      end
      S_ATTEN: begin
        mem_re    = (variant_q == VAR_CLASSIC);
        mem_raddr = AW'(W_WIDTH);
      end
      S_WB: begin
        mem_we = 1'b1;
        if (variant_q == VAR_ONESHOT) begin
          mem_waddr = unit_q ? AW'(W_DATA2) : AW'(W_DATA1);
          mem_wdata = WORD_W'(raw_q);
          mem_re    = 1'b1;
          mem_raddr = AW'(W_RAWINT);
        end else begin
          mem_wdata = (data_q & ~(DATA_MASK | DONE_MASK)) | WORD_W'(raw_q) | DONE_MASK;
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(W_RAWINT);
        mem_wdata = res_done_q ? (mem_rdata | ri_bit) : (mem_rdata & ~data_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_CLASSIC;
    end else if (chip_variant_we_i) begin
      if (chip_variant_i == VAR_SECOND) begin
        variant_q <= VAR_SECOND;
      end else if (chip_variant_i == VAR_ONESHOT) begin
        variant_q <= VAR_ONESHOT;
      end else begin
        variant_q <= VAR_CLASSIC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_N; i++) begin
        pad_q[i] <= '0;
      end
    end else if (pad_wr) begin
      pad_q[pad_widx] <= pad_millivolts_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            priority if ((opcode_i == OP_READ) && in_hit) begin
              state_q <= S_RDWAIT;
            end else if ((opcode_i == OP_WRITE) && in_hit) begin
              state_q <= S_DECODE;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_RDWAIT: state_q <= S_OUT;
        S_DECODE: begin
          priority if (variant_q == VAR_ONESHOT) begin
            priority if (os_start) begin
              state_q <= S_CALC;
            end else if (w_q == W_CLEAR) begin
              state_q <= S_RMW;
            end else begin
              state_q <= S_OUT;
            end
          end else if (st01) begin
            state_q <= S_ATTEN;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_ATTEN:  state_q <= (variant_q == VAR_CLASSIC) ? S_WIDTH : S_CALC;
        S_WIDTH:  state_q <= S_CALC;
        S_CALC:   state_q <= sat ? S_WB : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_WB;
          end
        end
        S_WB:     state_q <= (variant_q == VAR_ONESHOT) ? S_RMW : S_OUT;
        S_RMW:    state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          w_q        <= in_w;
          data_q     <= write_data_i;
          res_rd_q   <= '0;
          res_done_q <= 1'b0;
          res_unit_q <= 1'b0;
          res_raw_q  <= '0;
        end
      end
      S_RDWAIT: res_rd_q <= mem_rdata;
      S_DECODE: begin
        if (variant_q == VAR_ONESHOT) begin
          unit_q <= os_unit;
          ch_q   <= os_ch;
          at_q   <= data_q[OS_AT_LSB +: 2];
          en_q   <= os_en;
          bits_q <= BITS_FULL;
        end else begin
          unit_q <= unit01;
          ch_q   <= sel_ch;
          en_q   <= sel_found;
          bits_q <= BITS_FULL;
        end
      end
      S_ATTEN:  at_q <= mem_rdata[{ch_q, 1'b0} +: 2];
      S_WIDTH:  bits_q <= BITS_MIN + BITS_W'(mem_rdata[{unit_q, 1'b0} +: 2]);
      S_CALC: begin
        if (sat) begin
          raw_q <= maxraw;
        end
      end
      S_DIV: begin
        if (div_done) begin
          raw_q <= div_quo;
        end
      end
      S_WB: begin
        res_done_q <= 1'b1;
        res_unit_q <= unit_q;
        res_raw_q  <= raw_q;
      end
      default: begin
        res_done_q <= res_done_q;
      end
    endcase
    if (out_load) begin
      out_rd_q   <= res_rd_q;
      out_done_q <= res_done_q;
      out_unit_q <= res_unit_q;
      out_raw_q  <= res_raw_q;
    end
  end

  sarif_regfile #(
    .REG_WORDS (REG_WORDS)
  ) u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sarif_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (fs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_rd_q;
  assign conversion_done_o = out_done_q;
  assign conversion_unit_o = out_unit_q;
  assign conversion_raw_o  = out_raw_q;

  `SARIF_ASSERT(a_idle_result_clean, out_valid_o && !conversion_done_o |-> (conversion_raw_o == '0) && !conversion_unit_o, "item without conversion carries conversion fields")
  `SARIF_ASSERT(a_conv_no_read, out_valid_o && conversion_done_o |-> (read_data_o == '0), "conversion item carries read data")
  `SARIF_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
  `SARIF_ASSERT_NEXT(a_div_leaves, (state_q == S_DIV) && div_done, state_q == S_WB, "sequencer missed divider completion")

endmodule

`default_nettype wire

// ===== hdl/sarif_regfile.sv =====
// Register word file: single write port, one registered read port.
// Unwritten words read as their reset value; uses sarif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sarif_regfile
  import sarif_pkg::*;
#(
  parameter int REG_WORDS = REG_WORDS_DEF,
  localparam int AW = $clog2(REG_WORDS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0]    mem_q [REG_WORDS];
  logic [REG_WORDS-1:0] valid_q;
  logic [WORD_W-1:0]    rd_q;
  logic                 rvalid_q;
  logic [AW-1:0]        raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q     <= mem_q[raddr_i];
      rvalid_q <= valid_q[raddr_i];
      raddr_q  <= raddr_i;
    end
  end

  assign rdata_o = rvalid_q ? rd_q :
                   ((raddr_q == AW'(W_WIDTH)) ? WIDTH_RESET : '0);

endmodule

`default_nettype wire

// ===== hdl/sarif_div.sv =====
// Restoring divider, one quotient bit per cycle, for the raw-code scaling.
// Needs dividend / divisor < 2^RAW_W; uses sarif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sarif_div
  import sarif_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [FS_W-1:0]   divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [RAW_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(RAW_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FS_W-1:0]   rem_q;
  logic [RAW_W-1:0]  low_q;
  logic [FS_W-1:0]   dvs_q;
  logic [FS_W:0]     trial;
  logic              qbit;
  logic [FS_W:0]     diff;

  always_comb begin
    trial = {rem_q, low_q[RAW_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RAW_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[PROD_W-1:RAW_W];
      low_q <= dividend_i[RAW_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[FS_W-1:0] : trial[FS_W-1:0];
      low_q <= {low_q[RAW_W-2:0], qbit};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = low_q;

endmodule

`default_nettype wire
